// ===== hdl/dllt_pkg.sv =====
// ----------------------------------------------------------------------------
// dllt_pkg
// Shared types and constants for the two-lane lap timer: command codes,
// digit radices and the packed input and result words.
// ----------------------------------------------------------------------------
`default_nettype none

package dllt_pkg;

  localparam logic [2:0] CMD_TICK      = 3'd0;
  localparam logic [2:0] CMD_START     = 3'd1;
  localparam logic [2:0] CMD_LAP_MARK  = 3'd2;
  localparam logic [2:0] CMD_NEW_LAP   = 3'd3;
  localparam logic [2:0] CMD_SHOW_BEST = 3'd4;
  localparam logic [2:0] CMD_RESET     = 3'd5;

  localparam int MS_PER_TENTH   = 100;
  localparam int TENTHS_PER_SEC = 10;
  localparam int SEC_PER_MIN    = 60;

  localparam logic [15:0] HOLD_RESET = 16'd2000;

  localparam logic [1:0] ADDR_HOLD_MS = 2'd0;

  typedef struct packed {
    logic [2:0] command;
    logic       lane;
  } item_t;

  typedef struct packed {
    logic [5:0] seconds_a;
    logic [3:0] tenths_a;
    logic [5:0] seconds_b;
    logic [3:0] tenths_b;
    logic       live;
    logic       new_record;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/dual_lane_lap_timer.sv =====
// A word is accepted into the input register, and its result is then
// registered in the result register when the result side is not stalled.
// Throughput: one word per cycle while the result side is not stalled.
// The state update is a single pass of logic between the input register and
// the result register; each lane keeps its times as decimal digit counters.
// Reset (synchronous, active high) stops both lanes, clears all times, best
// laps and pipeline valids, and loads hold_ms with 2000.
// ----------------------------------------------------------------------------
// dual_lane_lap_timer
// Two-lane lap timer with display hold and best-lap memory, fed by
// millisecond ticks and lane events, reporting seconds and tenths per lane.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_lane_lap_timer #(
  parameter int TIME_BITS = 32
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   item_valid,
  output logic                  item_stall,
  input  dllt_pkg::item_t       item,
  output logic                  result_valid,
  input  wire                   result_stall,
  output dllt_pkg::result_t     result,
  input  wire                   psel,
  input  wire                   penable,
  input  wire                   pwrite,
  input  wire  [1:0]            paddr,
  input  wire  [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  typedef struct packed {
    logic [6:0] ms;
    logic [3:0] tenth;
    logic [5:0] sec;
  } digits_t;

  localparam logic [6:0] MS_LAST    = 7'(dllt_pkg::MS_PER_TENTH - 1);
  localparam logic [3:0] TENTH_LAST = 4'(dllt_pkg::TENTHS_PER_SEC - 1);
  localparam logic [5:0] SEC_LAST   = 6'(dllt_pkg::SEC_PER_MIN - 1);

  function automatic digits_t digits_inc(input digits_t d);
    digits_t r;
    r = d;
    if (d.ms == MS_LAST) begin
      r.ms = '0;
      if (d.tenth == TENTH_LAST) begin
        r.tenth = '0;
        r.sec   = (d.sec == SEC_LAST) ? 6'd0 : d.sec + 6'd1;
      end else begin
        r.tenth = d.tenth + 4'd1;
      end
    end else begin
      r.ms = d.ms + 7'd1;
    end
    return r;
  endfunction

  // Configuration
  logic [15:0] hold_ms;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr == dllt_pkg::ADDR_HOLD_MS);
  assign prdata    = (paddr == dllt_pkg::ADDR_HOLD_MS) ? {16'd0, hold_ms} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ms <= dllt_pkg::HOLD_RESET;
    end else if (cfg_write) begin
      hold_ms <= pwdata[15:0];
    end
  end

  // Input register and handshake
  logic            in_full;
  dllt_pkg::item_t item_r;
  logic            advance;
  logic            proc;

  assign advance    = !(result_valid && result_stall);
  assign proc       = in_full && advance;
  assign item_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (item_valid && !item_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      item_r <= item;
    end
  end

  // Lane state
  logic [TIME_BITS-1:0] elapsed      [2];
  digits_t              elapsed_d    [2];
  logic                 running      [2];
  logic [15:0]          hold_left    [2];
  digits_t              shown_d      [2];
  logic [TIME_BITS-1:0] best         [2];
  digits_t              best_d       [2];
  logic                 best_valid   [2];
  logic                 updating;

  logic [TIME_BITS-1:0] elapsed_next    [2];
  digits_t              elapsed_d_next  [2];
  logic                 running_next    [2];
  logic [15:0]          hold_left_next  [2];
  digits_t              shown_d_next    [2];
  logic [TIME_BITS-1:0] best_next       [2];
  digits_t              best_d_next     [2];
  logic                 best_valid_next [2];
  logic                 updating_next;
  logic                 record;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      elapsed_next[i]    = elapsed[i];
      elapsed_d_next[i]  = elapsed_d[i];
      running_next[i]    = running[i];
      hold_left_next[i]  = hold_left[i];
      shown_d_next[i]    = shown_d[i];
      best_next[i]       = best[i];
      best_d_next[i]     = best_d[i];
      best_valid_next[i] = best_valid[i];
    end
    updating_next = updating;
    record        = 1'b0;

    if (proc) begin
      case (item_r.command)
        dllt_pkg::CMD_TICK: begin
          for (int i = 0; i < 2; i++) begin
            if (running[i]) begin
              elapsed_next[i] = elapsed[i] + 1'b1;
              // The digit counters follow the binary count through its wrap.
              elapsed_d_next[i] = (elapsed[i] == '1) ? '0 : digits_inc(elapsed_d[i]);
            end
            if (hold_left[i] != 16'd0) begin
              hold_left_next[i] = hold_left[i] - 16'd1;
            end
            if (updating && hold_left_next[i] == 16'd0) begin
              shown_d_next[i] = running[i] ? elapsed_d_next[i] : '0;
            end
          end
        end
        dllt_pkg::CMD_START: begin
          for (int i = 0; i < 2; i++) begin
            if (item_r.lane == 1'(i)) begin
              elapsed_next[i]   = '0;
              elapsed_d_next[i] = '0;
              running_next[i]   = 1'b1;
            end
          end
          updating_next = 1'b1;
        end
        dllt_pkg::CMD_LAP_MARK: begin
          for (int i = 0; i < 2; i++) begin
            if (item_r.lane == 1'(i)) begin
              hold_left_next[i] = hold_ms;
            end
          end
        end
        dllt_pkg::CMD_NEW_LAP: begin
          for (int i = 0; i < 2; i++) begin
            if (item_r.lane == 1'(i)) begin
              if (running[i]) begin
                shown_d_next[i]   = elapsed_d[i];
                hold_left_next[i] = hold_ms;
                if (!best_valid[i] || elapsed[i] < best[i]) begin
                  best_next[i]       = elapsed[i];
                  best_d_next[i]     = elapsed_d[i];
                  best_valid_next[i] = 1'b1;
                  record             = 1'b1;
                end
              end
              elapsed_next[i]   = '0;
              elapsed_d_next[i] = '0;
              running_next[i]   = 1'b1;
            end
          end
          updating_next = 1'b1;
        end
        dllt_pkg::CMD_SHOW_BEST: begin
          updating_next = 1'b0;
          for (int i = 0; i < 2; i++) begin
            shown_d_next[i] = best_valid[i] ? best_d[i] : '0;
          end
        end
        dllt_pkg::CMD_RESET: begin
          updating_next = 1'b0;
          for (int i = 0; i < 2; i++) begin
            shown_d_next[i] = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        elapsed[i]    <= '0;
        elapsed_d[i]  <= '0;
        running[i]    <= 1'b0;
        hold_left[i]  <= '0;
        shown_d[i]    <= '0;
        best[i]       <= '0;
        best_d[i]     <= '0;
        best_valid[i] <= 1'b0;
      end
      updating <= 1'b0;
    end else begin
      for (int i = 0; i < 2; i++) begin
        elapsed[i]    <= elapsed_next[i];
        elapsed_d[i]  <= elapsed_d_next[i];
        running[i]    <= running_next[i];
        hold_left[i]  <= hold_left_next[i];
        shown_d[i]    <= shown_d_next[i];
        best[i]       <= best_next[i];
        best_d[i]     <= best_d_next[i];
        best_valid[i] <= best_valid_next[i];
      end
      updating <= updating_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      result.seconds_a  <= shown_d_next[0].sec;
      result.tenths_a   <= shown_d_next[0].tenth;
      result.seconds_b  <= shown_d_next[1].sec;
      result.tenths_b   <= shown_d_next[1].tenth;
      result.live       <= updating_next;
      result.new_record <= record;
    end
  end

`ifndef SYNTH
  // A new record only comes from a new lap, which always turns updates on.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.new_record |-> result.live)
    else $error("new_record without live");

  assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid && result_stall)
    else $error("input stalled while the result side is free");

  assert property (@(posedge clk) disable iff (rst)
    elapsed_d[0].ms <= MS_LAST && elapsed_d[0].tenth <= TENTH_LAST &&
    elapsed_d[1].ms <= MS_LAST && elapsed_d[1].tenth <= TENTH_LAST &&
    elapsed_d[0].sec <= SEC_LAST && elapsed_d[1].sec <= SEC_LAST)
    else $error("elapsed digit counter out of range");

  assert property (@(posedge clk)
    rst |=> !result_valid && !in_full)
    else $error("pipeline valid survived reset");
`endif

endmodule

`default_nettype wire
